/* rtl/sfd_pkg.sv */
`default_nettype none
package sfd_pkg;

  localparam int unsigned FrameBytes  = 25;
  localparam int unsigned NumChannels = 16;
  localparam int unsigned StoreDepth  = FrameBytes - 1;
  localparam int unsigned StoreBits   = StoreDepth * 8;
  localparam int unsigned ChanBits    = 11;
  localparam int unsigned IdxBits     = 4;
  localparam int unsigned CountBits   = 5;
  localparam int unsigned TickBits    = 16;
  localparam int unsigned OutDataBits = 24;

  localparam logic [7:0]           HeaderByte   = 8'h0F;
  localparam logic [CountBits-1:0] CountMax     = 5'd31;
  localparam logic [CountBits-1:0] CountFull    = 5'(StoreDepth);
  localparam logic [TickBits-1:0]  TickMax      = 16'hFFFF;
  localparam logic [TickBits-1:0]  TimeoutReset = 16'd10;
  // failsafe is bit 3 of byte 23
  localparam int unsigned          FailsafePos  = 23 * 8 + 3;

  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic KindChan   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // step codes of the sequencer
  localparam logic StepWait = 1'b0;
  localparam logic StepChan = 1'b1;

  typedef enum logic {
    CondFrameOk  = 1'b0,
    CondLastChan = 1'b1
  } cond_e;

  typedef struct packed {
    logic  take_input;
    logic  emit_chan;
    cond_e cond;
    logic  next_seq;
    logic  next_hit;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic step);
    ctrl_word_t w;
    unique case (step)
      StepWait: w = '{take_input: 1'b1, emit_chan: 1'b0, cond: CondFrameOk,
                      next_seq: StepWait, next_hit: StepChan};
      StepChan: w = '{take_input: 1'b0, emit_chan: 1'b1, cond: CondLastChan,
                      next_seq: StepChan, next_hit: StepWait};
      default:  w = '{take_input: 1'b1, emit_chan: 1'b0, cond: CondFrameOk,
                      next_seq: StepWait, next_hit: StepChan};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/sbus_frame_decoder_unit.sv */
`default_nettype none
// channel   direction  beat content
// s_axis    in         tdata[7:0] data_byte, tuser operation, tlast burst_end
// m_axis    out        tdata channel_index/value, failsafe, link_lost; tuser kind;
//                      tlast last
// cfg       in         cfg_data_i timeout_ticks, written on cfg_valid_i (always ready)
//
// A valid frame's end beat then runs sixteen channel steps, one per cycle the
// output register is free. The two-step control ROM and its step register
// set this.
// rst_ni clears counters, the link-lost flag and the sequencer; the frame store and failsafe flag are not reset.
// s_axis_tready drops while channels are emitted or the output register is stalled.
module sbus_frame_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // operation
  input  wire logic        s_axis_tlast,   // burst_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                           // [15] failsafe, [16] link_lost, [23:17] zero
  output logic             m_axis_tuser,   // kind
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic                                step_q, step_d;
  logic [sfd_pkg::StoreBits-1:0]       frame_q, frame_d;
  logic [sfd_pkg::CountBits-1:0]       count_q, count_d;
  logic [sfd_pkg::TickBits-1:0]        ticks_q, ticks_d;
  logic                                lost_q, lost_d;
  logic [sfd_pkg::TickBits-1:0]        timeout_q;
  logic [sfd_pkg::IdxBits-1:0]         chan_q, chan_d;
  logic                                fs_q, fs_d;
  logic                                out_valid_q, out_valid_d;
  logic [sfd_pkg::OutDataBits-1:0]     out_data_q, out_data_d;
  logic                                out_kind_q, out_kind_d;
  logic                                out_last_q, out_last_d;

  sfd_pkg::ctrl_word_t cw;
  logic slot_free;
  logic in_fire;
  logic frame_ok;
  logic hit;

  assign cw            = sfd_pkg::ucode_rom(step_q);
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = cw.take_input && slot_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign frame_ok      = (count_q == sfd_pkg::CountFull) &&
                         (frame_q[7:0] == sfd_pkg::HeaderByte);
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    unique case (cw.cond)
      sfd_pkg::CondFrameOk:  hit = in_fire && (s_axis_tuser == sfd_pkg::OpByte) &&
                                   s_axis_tlast && frame_ok;
      sfd_pkg::CondLastChan: hit = slot_free &&
                                   (chan_q == sfd_pkg::IdxBits'(sfd_pkg::NumChannels - 1));
      default:               hit = 1'b0;
    endcase
  end

  always_comb begin
    step_d      = hit ? cw.next_hit : cw.next_seq;
    frame_d     = frame_q;
    count_d     = count_q;
    ticks_d     = ticks_q;
    lost_d      = lost_q;
    chan_d      = chan_q;
    fs_d        = fs_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;

    if (in_fire) begin
      priority if (s_axis_tuser == sfd_pkg::OpTick) begin
        if (ticks_q != sfd_pkg::TickMax) ticks_d = ticks_q + 1'b1;
        lost_d      = ticks_d > timeout_q;
        out_valid_d = 1'b1;
        out_kind_d  = sfd_pkg::KindStatus;
        out_last_d  = 1'b1;
        out_data_d  = '0;
        out_data_d[16] = lost_d;
      end else if (!s_axis_tlast) begin
        // shift in; byte 0 ends up at the bottom after a full frame
        if (count_q < sfd_pkg::CountFull)
          frame_d = {s_axis_tdata, frame_q[sfd_pkg::StoreBits-1:8]};
        if (count_q != sfd_pkg::CountMax) count_d = count_q + 1'b1;
      end else begin
        count_d = '0;
        if (frame_ok) begin
          ticks_d = '0;
          lost_d  = 1'b0;
          fs_d    = frame_q[sfd_pkg::FailsafePos];
          chan_d  = '0;
        end
      end
    end

    if (cw.emit_chan && slot_free) begin
      out_valid_d = 1'b1;
      out_kind_d  = sfd_pkg::KindChan;
      out_last_d  = (chan_q == sfd_pkg::IdxBits'(sfd_pkg::NumChannels - 1));
      out_data_d  = '0;
      out_data_d[3:0]  = chan_q;
      out_data_d[14:4] = frame_q[8 +: sfd_pkg::ChanBits];
      out_data_d[15]   = fs_q;
      // advance to the next 11-bit field
      frame_d = frame_q >> sfd_pkg::ChanBits;
      chan_d  = chan_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= sfd_pkg::StepWait;
      count_q     <= '0;
      ticks_q     <= '0;
      lost_q      <= 1'b0;
      timeout_q   <= sfd_pkg::TimeoutReset;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      ticks_q     <= ticks_d;
      lost_q      <= lost_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) timeout_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q    <= frame_d;
    fs_q       <= fs_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
